// ===== rtl/core/byte_ring_fifo_bulk_defines.svh =====
// Assertion macros shared by the checker files of the byte ring FIFO.
// Both macros expect signals named clk and arst_n in the scope where they are used.
`ifndef BYTE_RING_FIFO_BULK_DEFINES_SVH
`define BYTE_RING_FIFO_BULK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRFB_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte ring fifo check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRFB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte ring fifo check failed");

`endif

// ===== rtl/core/brfb_pkg.sv =====
`default_nettype none
package brfb_pkg;

	// Ring geometry.
	localparam int DEPTH_LOG2  = 12;
	localparam int MAX_REQUEST = 64;
	localparam int PTR_W       = DEPTH_LOG2 + 1;
	localparam int LANES       = 8;
	localparam int LANE_W      = 3;
	localparam int ROW_W       = DEPTH_LOG2 - LANE_W;
	localparam int ROWS        = 1 << ROW_W;

	// Field widths.
	localparam int OP_W   = 3;
	localparam int LEN_W  = 7;
	localparam int DATA_W = 64;
	localparam int BC_W   = 4;

	localparam logic [PTR_W-1:0] RING_SIZE = {1'b1, {DEPTH_LOG2{1'b0}}};
	localparam logic [LEN_W-1:0] MAX_REQ_L = LEN_W'(MAX_REQUEST);
	localparam logic [LEN_W-1:0] LANES_L   = LEN_W'(LANES);

	typedef enum logic [OP_W-1:0] {
		OP_PUT_PART  = 3'd0,
		OP_PUT_ALL   = 3'd1,
		OP_GET_PART  = 3'd2,
		OP_GET_ALL   = 3'd3,
		OP_PEEK_PART = 3'd4,
		OP_PEEK_ALL  = 3'd5,
		OP_COMMIT    = 3'd6
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // an item is taken this cycle
		logic single;  // load the output register with a one-result response
		logic issue;   // read the next chunk from the lane memories
		logic move;    // move the read chunk into the output register
	} brfb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic read_go;     // the offered item is a get or peek that moves bytes
		logic last_chunk;  // the next chunk to issue is the final one
	} brfb_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/brfb_ram.sv =====
`default_nettype none
module brfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/brfb_ctrl.sv =====
`default_nettype none
module brfb_ctrl import brfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  brfb_sts_t sts,
	output brfb_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   pend_q;
	logic   out_valid_q;
	logic   out_free;
	logic   take;

	assign out_free = !out_valid_q || out_ready;
	assign take     = out_valid_q && out_ready;
	assign in_ready = (state_q == ST_IDLE) && !pend_q && out_free;

	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.single = cmd.accept && !sts.read_go;
		cmd.move   = pend_q && out_free;
		cmd.issue  = (state_q == ST_READ) && (!pend_q || cmd.move);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.read_go) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cmd.issue && sts.last_chunk) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.issue) begin
				pend_q <= 1'b1;
			end else if (cmd.move) begin
				pend_q <= 1'b0;
			end

			if (cmd.single || cmd.move) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/brfb_dpath.sv =====
`default_nettype none
module brfb_dpath import brfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  brfb_cmd_t         cmd,
	output brfb_sts_t         sts,
	input  logic [OP_W-1:0]   operation,
	input  logic [LEN_W-1:0]  length,
	input  logic [DATA_W-1:0] put_data,
	output logic [DATA_W-1:0] read_data,
	output logic [BC_W-1:0]   byte_count,
	output logic [LEN_W-1:0]  moved_count,
	output logic              last
);

	logic [PTR_W-1:0]      wp_q;
	logic [PTR_W-1:0]      rp_q;
	logic [PTR_W-1:0]      used_raw;
	logic [PTR_W-1:0]      used;
	logic [PTR_W-1:0]      room;
	logic [LEN_W-1:0]      put_len;
	logic [LEN_W-1:0]      rd_len;
	logic [LEN_W-1:0]      n_put_all;
	logic [LEN_W-1:0]      n_put_part;
	logic [LEN_W-1:0]      n_rd_all;
	logic [LEN_W-1:0]      n_rd_part;
	logic [LEN_W-1:0]      n_commit;
	logic [LEN_W-1:0]      n;
	logic                  is_put;
	logic                  is_read;
	logic                  advance;

	// Request state of a get or peek in progress.
	logic [DEPTH_LOG2-1:0] addr_q;
	logic [LEN_W-1:0]      rem_q;
	logic [LEN_W-1:0]      moved_req_q;
	logic [BC_W-1:0]       chunk_cnt;

	// Chunk in flight through the lane memories.
	logic [LANE_W-1:0]     lo_s1;
	logic [BC_W-1:0]       cnt_s1;
	logic                  last_s1;

	logic [DATA_W-1:0]     read_data_q;
	logic [BC_W-1:0]       byte_count_q;
	logic [LEN_W-1:0]      moved_q;
	logic                  last_q;

	logic [7:0]            bank_rdata [LANES];
	logic [DATA_W-1:0]     chunk_word;

	always_comb begin
		used_raw   = wp_q - rp_q;
		used       = (used_raw > RING_SIZE) ? RING_SIZE : used_raw;
		room       = RING_SIZE - used;
		put_len    = (length > LANES_L) ? LANES_L : length;
		rd_len     = (length > MAX_REQ_L) ? MAX_REQ_L : length;
		n_put_all  = (PTR_W'(put_len) <= room) ? put_len : '0;
		n_put_part = (PTR_W'(put_len) < room) ? put_len : room[LEN_W-1:0];
		n_rd_all   = (PTR_W'(rd_len) <= used) ? rd_len : '0;
		n_rd_part  = (PTR_W'(rd_len) < used) ? rd_len : used[LEN_W-1:0];
		n_commit   = (PTR_W'(length) < used) ? length : used[LEN_W-1:0];

		n       = '0;
		is_put  = 1'b0;
		is_read = 1'b0;
		advance = 1'b0;
		unique case (operation)
			OP_PUT_PART: begin
				n      = n_put_part;
				is_put = 1'b1;
			end
			OP_PUT_ALL: begin
				n      = n_put_all;
				is_put = 1'b1;
			end
			OP_GET_PART: begin
				n       = n_rd_part;
				is_read = 1'b1;
				advance = 1'b1;
			end
			OP_GET_ALL: begin
				n       = n_rd_all;
				is_read = 1'b1;
				advance = 1'b1;
			end
			OP_PEEK_PART: begin
				n       = n_rd_part;
				is_read = 1'b1;
			end
			OP_PEEK_ALL: begin
				n       = n_rd_all;
				is_read = 1'b1;
			end
			OP_COMMIT: begin
				n       = n_commit;
				advance = 1'b1;
			end
			default: begin
				n = '0;
			end
		endcase

		sts.read_go    = is_read && (n != '0);
		sts.last_chunk = (rem_q <= LANES_L);
		chunk_cnt      = (rem_q > LANES_L) ? BC_W'(LANES) : rem_q[BC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (cmd.accept) begin
			if (is_put) begin
				wp_q <= wp_q + PTR_W'(n);
			end
			if (advance) begin
				rp_q <= rp_q + PTR_W'(n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q      <= rp_q[DEPTH_LOG2-1:0];
			rem_q       <= n;
			moved_req_q <= n;
		end else if (cmd.issue) begin
			addr_q  <= addr_q + DEPTH_LOG2'(LANES);
			rem_q   <= rem_q - LEN_W'(chunk_cnt);
			lo_s1   <= addr_q[LANE_W-1:0];
			cnt_s1  <= chunk_cnt;
			last_s1 <= (rem_q <= LANES_L);
		end
	end

	// One memory per byte lane; consecutive ring addresses fall in consecutive lanes,
	// so any eight consecutive bytes touch each lane exactly once.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [LANE_W-1:0] w_off;
		logic [LANE_W-1:0] w_lo;
		logic [LANE_W-1:0] r_lo;
		logic [ROW_W-1:0]  w_row;
		logic [ROW_W-1:0]  r_row;
		logic              we;

		always_comb begin
			w_lo  = wp_q[LANE_W-1:0];
			w_off = LANE_W'(g) - w_lo;
			we    = cmd.accept && is_put && (LEN_W'(w_off) < n);
			w_row = (LANE_W'(g) >= w_lo) ? wp_q[DEPTH_LOG2-1:LANE_W]
				: wp_q[DEPTH_LOG2-1:LANE_W] + ROW_W'(1);
			r_lo  = addr_q[LANE_W-1:0];
			r_row = (LANE_W'(g) >= r_lo) ? addr_q[DEPTH_LOG2-1:LANE_W]
				: addr_q[DEPTH_LOG2-1:LANE_W] + ROW_W'(1);
		end

		brfb_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(w_row),
			.wdata(put_data[8*w_off +: 8]),
			.re   (cmd.issue),
			.raddr(r_row),
			.rdata(bank_rdata[g])
		);
	end

	// Rotate the lanes so the chunk's first byte lands in bits 7:0; clear unused bytes.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			chunk_word[8*i +: 8] = (BC_W'(i) < cnt_s1) ?
				bank_rdata[lo_s1 + LANE_W'(i)] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single) begin
			read_data_q  <= '0;
			byte_count_q <= '0;
			moved_q      <= n;
			last_q       <= 1'b1;
		end else if (cmd.move) begin
			read_data_q  <= chunk_word;
			byte_count_q <= cnt_s1;
			moved_q      <= moved_req_q;
			last_q       <= last_s1;
		end
	end

	assign read_data   = read_data_q;
	assign byte_count  = byte_count_q;
	assign moved_count = moved_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/byte_ring_fifo_bulk.sv =====
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   operation, length, put_data
// output   out        out_valid / out_ready read_data, byte_count, moved_count, last
//
// Put, commit-read and unused codes give one result, in the cycle after they are accepted.
// Get and peek of n bytes give ceil(n/8) results (one when nothing moves), one per cycle
// while the output is unstalled; the eight byte-lane memories deliver one 8-byte span a cycle.
// The next item is taken no earlier than the edge at which the previous item's last result
// leaves the output register, so a read occupies the block until its last result is taken.
// Reset clears the pointers and handshake state only; no clearing pass runs on the store.
// A stalled output holds the result and, behind it, at most one chunk in the lane memories.
`default_nettype none
module byte_ring_fifo_bulk import brfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [LEN_W-1:0]  length,
	input  logic [DATA_W-1:0] put_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] read_data,
	output logic [BC_W-1:0]   byte_count,
	output logic [LEN_W-1:0]  moved_count,
	output logic              last
);

	// The controller owns both handshakes and sequences the chunks of a read;
	// the datapath owns the pointers, the lane memories and the output register.
	brfb_cmd_t cmd;
	brfb_sts_t sts;

	brfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// All sizing of a request (fill level, room, clamping) happens in the accept cycle,
	// so pointers are updated right away; a get reads from the saved old read pointer.
	brfb_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.length     (length),
		.put_data   (put_data),
		.read_data  (read_data),
		.byte_count (byte_count),
		.moved_count(moved_count),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== rtl/core/brfb_checker.sv =====
`default_nettype none
`include "byte_ring_fifo_bulk_defines.svh"
module brfb_checker import brfb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] read_data,
	input logic [BC_W-1:0]   byte_count,
	input logic [LEN_W-1:0]  moved_count,
	input logic              last
);

	`BRFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`BRFB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(read_data) && $stable(byte_count) && $stable(moved_count) && $stable(last))
	`BRFB_ASSERT_SAME(a_count_range, out_valid, byte_count <= BC_W'(LANES))
	`BRFB_ASSERT_SAME(a_empty_is_last, out_valid && byte_count == '0, last)
	`BRFB_ASSERT_SAME(a_inner_full, out_valid && !last, byte_count == BC_W'(LANES) && moved_count > LANES_L)

endmodule

bind byte_ring_fifo_bulk brfb_checker u_brfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.read_data  (read_data),
	.byte_count (byte_count),
	.moved_count(moved_count),
	.last       (last)
);
`default_nettype wire
